[rtl/core/abpf_pkg.sv]
// shared types and constants for the atom bond pair finder
`default_nettype none
package abpf_pkg;

  localparam int MAX_ATOMS = 64;
  localparam int IDX_W     = $clog2(MAX_ATOMS);
  localparam int CNT_W     = $clog2(MAX_ATOMS + 1);
  localparam int COORD_W   = 16;
  localparam int SQ_W      = 32;
  localparam int CUT_W     = 34;
  localparam int OUT_IDX_W = 6;

  localparam logic [CUT_W-1:0] CUTOFF_RESET = CUT_W'(2500);

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;
  localparam logic STAT_PAIR  = 1'b0;
  localparam logic STAT_FULL  = 1'b1;

  typedef struct packed {
    logic                       cmd;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
  } abpf_in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] first_index;
    logic [OUT_IDX_W-1:0] second_index;
    logic                 status;
    logic                 last_of_run;
  } abpf_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } abpf_atom_t;

  // travels with each stored atom read out of the table
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic             fin;
  } abpf_tag_t;

  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic             fin;
  } abpf_hit_t;

endpackage
`default_nettype wire

[rtl/core/atom_bond_pair_finder.sv]
// top level: atom table memory, scan sequencer and result emission
// an add with n > 0 stored atoms keeps busy high while it scans them; an add to an
// empty table leaves busy low; one stored atom is read per cycle from the memory
// results leave in stored index order, the last one in the same cycle that busy falls
// clear and table-full commands leave busy low; a full-table result follows at once
// synchronous active-low reset empties the table and loads the cutoff with 2500
`default_nettype none
module atom_bond_pair_finder (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  abpf_pkg::abpf_in_t           in_data,
  output logic                         out_valid,
  output abpf_pkg::abpf_out_t          out_data,
  input  wire                          cfg_we,
  input  wire [abpf_pkg::CUT_W-1:0]    cfg_wdata
);
  import abpf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] limit_r, limit_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CUT_W-1:0] cutoff_r;
  abpf_atom_t       probe_r, probe_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic             fin_r;
  logic             out_valid_r, out_valid_nxt;
  abpf_out_t        out_r, out_nxt;

  abpf_atom_t       mem [MAX_ATOMS];
  abpf_atom_t       rd_data_r;
  abpf_tag_t        rd_tag, rd_tag_r;
  logic             wr_en;
  abpf_atom_t       wr_data;
  abpf_hit_t        hit;
  logic             accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign wr_data = '{x: in_data.coord_x, y: in_data.coord_y, z: in_data.coord_z};

  // coordinate table: written on an accepted add to a table that is not full, read during the scan
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= wr_data;
    end
    if (rd_tag.vld) begin
      rd_data_r <= mem[rd_tag.idx];
    end
  end

  always_ff @(posedge clk) begin
    rd_tag_r.idx <= rd_tag.idx;
    rd_tag_r.fin <= rd_tag.fin;
    if (!rst_n) begin
      rd_tag_r.vld <= 1'b0;
    end else begin
      rd_tag_r.vld <= rd_tag.vld;
    end
  end

  abpf_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_i    (rd_tag_r),
    .stored_i (rd_data_r),
    .probe_i  (probe_r),
    .cutoff_i (cutoff_r),
    .hit_o    (hit)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    limit_nxt     = limit_r;
    count_nxt     = count_r;
    probe_nxt     = probe_r;
    pend_vld_nxt  = pend_vld_r;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    rd_tag.vld    = 1'b0;
    rd_tag.idx    = idx_r[IDX_W-1:0];
    rd_tag.fin    = ((idx_r + CNT_W'(1)) == limit_r);

    // a new close atom releases the one held back, which is then not the last
    if (hit.vld && hit.hit) begin
      if (pend_vld_r) begin
        out_valid_nxt = 1'b1;
        out_nxt = '{first_index:  OUT_IDX_W'(pend_idx_r),
                    second_index: OUT_IDX_W'(limit_r),
                    status:       STAT_PAIR,
                    last_of_run:  1'b0};
      end
      pend_vld_nxt = 1'b1;
      pend_idx_nxt = hit.idx;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_data.cmd == CMD_CLEAR) begin
            count_nxt = '0;
          end else if (count_r == CNT_W'(MAX_ATOMS)) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{first_index:  '0,
                        second_index: '0,
                        status:       STAT_FULL,
                        last_of_run:  1'b1};
          end else begin
            wr_en        = 1'b1;
            count_nxt    = count_r + CNT_W'(1);
            limit_nxt    = count_r;
            probe_nxt    = wr_data;
            idx_nxt      = '0;
            pend_vld_nxt = 1'b0;
            if (count_r != '0) begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        rd_tag.vld = 1'b1;
        idx_nxt    = idx_r + CNT_W'(1);
        if (rd_tag.fin) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (fin_r) begin
          if (pend_vld_r) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{first_index:  OUT_IDX_W'(pend_idx_r),
                        second_index: OUT_IDX_W'(limit_r),
                        status:       STAT_PAIR,
                        last_of_run:  1'b1};
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    limit_r    <= limit_nxt;
    probe_r    <= probe_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_r      <= out_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cutoff_r    <= CUTOFF_RESET;
      pend_vld_r  <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_vld_r  <= pend_vld_nxt;
      fin_r       <= hit.vld && hit.fin;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cutoff_r <= cfg_wdata;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ATOMS)) else $error("atom count past table size");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_tag.vld |-> (idx_r < limit_r)) else $error("scan read past stored atoms");

  a_no_hit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    hit.vld |-> (state_r != ST_IDLE)) else $error("compare beat while idle");

  a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == STAT_FULL) |-> out_r.last_of_run)
    else $error("full-table beat not marked last");

  a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_r && state_r == ST_WAIT) |=> (state_r == ST_IDLE))
    else $error("scan end did not return to idle");

endmodule
`default_nettype wire

[rtl/core/abpf_dist.sv]
// two-stage squared distance and cutoff compare
`default_nettype none
module abpf_dist (
  input  wire                          clk,
  input  wire                          rst_n,
  input  abpf_pkg::abpf_tag_t          tag_i,
  input  abpf_pkg::abpf_atom_t         stored_i,
  input  abpf_pkg::abpf_atom_t         probe_i,
  input  wire [abpf_pkg::CUT_W-1:0]    cutoff_i,
  output abpf_pkg::abpf_hit_t          hit_o
);
  import abpf_pkg::*;

  logic [SQ_W-1:0] sq_x, sq_y, sq_z;
  logic [SQ_W-1:0] sq_x_r, sq_y_r, sq_z_r;
  abpf_tag_t       tag_r;
  logic [CUT_W-1:0] sum;
  abpf_hit_t       hit_r;

  function automatic logic [SQ_W-1:0] sq_diff(input logic signed [COORD_W-1:0] a,
                                               input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic [COORD_W-1:0]      m;
    logic [SQ_W-1:0]         m_ext;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
    m_ext = SQ_W'(m);
    return SQ_W'(m_ext * m_ext);
  endfunction

  assign sq_x = sq_diff(probe_i.x, stored_i.x);
  assign sq_y = sq_diff(probe_i.y, stored_i.y);
  assign sq_z = sq_diff(probe_i.z, stored_i.z);

  always_ff @(posedge clk) begin
    sq_x_r <= sq_x;
    sq_y_r <= sq_y;
    sq_z_r <= sq_z;
    tag_r.idx <= tag_i.idx;
    tag_r.fin <= tag_i.fin;
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else begin
      tag_r.vld <= tag_i.vld;
    end
  end

  // three squares of 16-bit magnitudes fit in 34 bits
  assign sum = CUT_W'(sq_x_r) + CUT_W'(sq_y_r) + CUT_W'(sq_z_r);

  always_ff @(posedge clk) begin
    hit_r.hit <= (sum <= cutoff_i);
    hit_r.idx <= tag_r.idx;
    hit_r.fin <= tag_r.fin;
    if (!rst_n) begin
      hit_r.vld <= 1'b0;
    end else begin
      hit_r.vld <= tag_r.vld;
    end
  end

  assign hit_o = hit_r;

  a_fin_has_vld: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r.vld |-> $past(tag_r.vld)) else $error("hit beat without a compare");

endmodule
`default_nettype wire

[verif/tb_top.sv]
// self-checking testbench for atom_bond_pair_finder: random clustered atoms, scoreboard class
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import abpf_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  // covers the longest scan and its trailing result
  localparam int SCAN_TAIL = MAX_ATOMS + 8;
  localparam int DRAIN_LIMIT = 2000;
  localparam int MAX_REPORTS = 20;
  localparam logic [CUT_W-1:0] CUTOFF_MAX = '1;

  // predicts the pair and full-table beats of each command and checks them in order
  class bond_scoreboard;
    logic [CUT_W-1:0] cutoff;
    abpf_atom_t atoms[MAX_ATOMS];
    int unsigned n_stored;
    abpf_out_t pairs_due[$];
    int unsigned errors, n_cmds, n_clears, n_full, n_checked;

    function new();
      cutoff = CUTOFF_RESET;
      n_stored = 0;
    endfunction

    function longint unsigned axis_sq(logic signed [COORD_W-1:0] a,
                                      logic signed [COORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
    endfunction

    function void note_command(abpf_in_t c);
      abpf_atom_t a;
      abpf_out_t held;
      bit have;
      longint unsigned d2;
      n_cmds++;
      if (c.cmd == CMD_CLEAR) begin
        n_clears++;
        n_stored = 0;
        return;
      end
      if (n_stored >= MAX_ATOMS) begin
        n_full++;
        held = '0;
        held.status = STAT_FULL;
        held.last_of_run = 1'b1;
        pairs_due.push_back(held);
        return;
      end
      have = 1'b0;
      held = '0;
      for (int i = 0; i < n_stored; i++) begin
        d2 = axis_sq(c.coord_x, atoms[i].x) + axis_sq(c.coord_y, atoms[i].y)
           + axis_sq(c.coord_z, atoms[i].z);
        if (d2 <= cutoff) begin
          // hold one back so the final pair can carry last_of_run
          if (have) pairs_due.push_back(held);
          held.first_index = OUT_IDX_W'(i);
          held.second_index = OUT_IDX_W'(n_stored);
          held.status = STAT_PAIR;
          held.last_of_run = 1'b0;
          have = 1'b1;
        end
      end
      if (have) begin
        held.last_of_run = 1'b1;
        pairs_due.push_back(held);
      end
      a.x = c.coord_x;
      a.y = c.coord_y;
      a.z = c.coord_z;
      atoms[n_stored] = a;
      n_stored++;
    endfunction

    function void check_pair(abpf_out_t got);
      abpf_out_t want;
      if (pairs_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected beat, got first %0d second %0d status %0d last %0d",
                   $time, got.first_index, got.second_index, got.status, got.last_of_run);
        return;
      end
      want = pairs_due.pop_front();
      n_checked++;
      if (got.first_index !== want.first_index || got.second_index !== want.second_index ||
          got.status !== want.status || got.last_of_run !== want.last_of_run) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch, expected first %0d second %0d status %0d last %0d, %s",
                   $time, want.first_index, want.second_index, want.status,
                   want.last_of_run,
                   $sformatf("got first %0d second %0d status %0d last %0d",
                             got.first_index, got.second_index, got.status,
                             got.last_of_run));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  abpf_in_t in_data = '0;
  logic cfg_we = 1'b0;
  logic [CUT_W-1:0] cfg_wdata = '0;
  logic busy;
  logic out_valid;
  abpf_out_t out_data;
  int unsigned cycles = 0;
  bond_scoreboard sb;

  atom_bond_pair_finder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("atom_bond_pair_finder test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_pair(out_data);
  end

  function automatic abpf_in_t make_cmd(logic cmd, logic [COORD_W-1:0] x,
                                        logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
    abpf_in_t c;
    c.cmd = cmd;
    c.coord_x = x;
    c.coord_y = y;
    c.coord_z = z;
    return c;
  endfunction

  function automatic logic [COORD_W-1:0] near(logic [COORD_W-1:0] ctr, int spread);
    int off;
    off = int'($urandom_range(2 * spread)) - spread;
    return ctr + COORD_W'(off);
  endfunction

  // start stays high until the beat is taken at an edge with busy low
  task automatic send(input abpf_in_t c);
    in_data <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_command(c);
  endtask

  // random idle gaps between commands, drawn with a chance of idle_pct percent, up to SCAN_TAIL long
  task automatic pause(input int idle_pct);
    int gap;
    gap = 0;
    if (int'($urandom_range(99)) < idle_pct) gap = $urandom_range(1, SCAN_TAIL);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (sb.pairs_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    while (busy !== 1'b0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // busy is low here, so this is an idle margin after the last scan has ended
    repeat (SCAN_TAIL) @(posedge clk);
  endtask

  task automatic set_cutoff(input logic [CUT_W-1:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.cutoff = value;
  endtask

  task automatic run_phase(input logic [CUT_W-1:0] cut, input int idle_pct,
                           input int spread, input int clear_pct, input int n_items);
    abpf_in_t c;
    logic [COORD_W-1:0] cx, cy, cz;
    int roll;
    set_cutoff(cut);
    send(make_cmd(CMD_CLEAR, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom)));
    cx = COORD_W'($urandom);
    cy = COORD_W'($urandom);
    cz = COORD_W'($urandom);
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(99);
      if ($urandom_range(15) == 0) begin
        cx = COORD_W'($urandom);
        cy = COORD_W'($urandom);
        cz = COORD_W'($urandom);
      end
      if (roll < clear_pct)
        c = make_cmd(CMD_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom));
      else if (roll < clear_pct + 10)
        c = make_cmd(CMD_ADD, COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom));
      else
        c = make_cmd(CMD_ADD, near(cx, spread), near(cy, spread), near(cz, spread));
      send(c);
      pause(idle_pct);
    end
  endtask

  initial begin
    logic [CUT_W-1:0] mid_cut;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default cutoff of 2500
    send(make_cmd(CMD_ADD, 16'sd0, 16'sd0, 16'sd0));         // no partner
    send(make_cmd(CMD_ADD, 16'sd30, 16'sd40, 16'sd0));       // exactly at cutoff
    send(make_cmd(CMD_ADD, 16'sd30, 16'sd40, 16'sd1));       // one past for atom 0
    send(make_cmd(CMD_ADD, 16'h8000, 16'h8000, 16'h8000));
    send(make_cmd(CMD_ADD, 16'h7fff, 16'h7fff, 16'h7fff));
    send(make_cmd(CMD_ADD, 16'h8000, 16'h8000, 16'h8000));
    send(make_cmd(CMD_ADD, 16'h7fff, 16'h7fff, 16'h7fff));
    send(make_cmd(CMD_ADD, 16'hffff, 16'hffff, 16'hffff));
    send(make_cmd(CMD_CLEAR, 16'h7fff, 16'h8000, 16'hffff)); // coords ignored
    send(make_cmd(CMD_ADD, 16'sd0, 16'sd0, 16'sd0));
    // largest cutoff: even opposite corners pair up
    set_cutoff(CUTOFF_MAX);
    send(make_cmd(CMD_ADD, 16'h8000, 16'h7fff, 16'h8000));
    send(make_cmd(CMD_ADD, 16'h7fff, 16'h8000, 16'h7fff));
    // zero cutoff: only coincident atoms
    set_cutoff('0);
    send(make_cmd(CMD_ADD, 16'h7fff, 16'h8000, 16'h7fff));
    send(make_cmd(CMD_ADD, 16'h7fff, 16'h8000, 16'h7ffe));
    send(make_cmd(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000));

    // random phases; the ones without clears run the table full
    mid_cut = {2'($urandom_range(3)), 32'($urandom)};
    run_phase(CUTOFF_RESET, 0, 30, 0, 110);
    run_phase('0, 79, 1, 3, 90);
    run_phase(CUTOFF_MAX, 15, 32767, 4, 90);
    run_phase(mid_cut, 0, 30000, 2, 100);
    run_phase(CUTOFF_RESET, 79, 25, 0, 110);

    settle();
    if (sb.pairs_due.size() != 0) begin
      sb.errors += sb.pairs_due.size();
      $display("%0t: %0d expected beats never arrived", $time, sb.pairs_due.size());
    end
    $display("covered %0d commands (%0d clears, %0d adds refused on a full table), %0d beats",
             sb.n_cmds, sb.n_clears, sb.n_full, sb.n_checked);
    $display("cutoffs: reset value, zero, all ones, random; sender idle 0, 15 and 79 percent");
    if (sb.errors == 0)
      $display("atom_bond_pair_finder test passed");
    else
      $display("atom_bond_pair_finder test failed");
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
rtl/core/abpf_pkg.sv
rtl/core/abpf_dist.sv
rtl/core/atom_bond_pair_finder.sv
verif/tb_top.sv
